### rtl/ctj_pkg.sv
// Shared types, constants and command codes for the triangle join counter.
`default_nettype none
package ctj_pkg;
	localparam int DEF_OFFSET_DEPTH = 4096;
	localparam int DEF_ADJ_DEPTH = 16384;
	localparam int DEF_SCAN_OFFSET_DEPTH = 64;
	localparam int DEF_SCAN_DEPTH = 4096;
	localparam int DEF_VERTEX_BITS = 32;

	localparam int CMD_W = 3;
	localparam int ADDR_W = 14;
	localparam int DATA_W = 32;
	localparam int CNT_W = 32;
	localparam int OFF_W = 15;
	localparam int SOFF_W = 13;
	localparam int LABEL_W = 6;
	localparam int BASE_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CMD_W-1:0] CMD_WR_OFF = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_ADJ = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_SOFF = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WR_SVERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RUN = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SCAN_LABEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SECOND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_THIRD = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic [CNT_W-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction
endpackage
`default_nettype wire

### rtl/ctj_if.sv
// Command and result channel interfaces of the triangle join counter.
`default_nettype none
interface ctj_cmd_if
	import ctj_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] data;
	modport source (output valid, cmd, addr, data, input ready);
	modport sink (input valid, cmd, addr, data, output ready);
endinterface

interface ctj_res_if
	import ctj_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] pair_count;
	logic [CNT_W-1:0] match_count;
	logic             saturated;
	modport source (output valid, pair_count, match_count, saturated, input ready);
	modport sink (input valid, pair_count, match_count, saturated, output ready);
endinterface
`default_nettype wire

### rtl/ctj_ram.sv
// Simple dual-port RAM with registered read and a zero read for out-of-range indexes.
`default_nettype none
module ctj_ram
	import ctj_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic                     rin,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic             rin_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
			rin_q <= rin;
		end
	end

	assign rdata = rin_q ? rd_q : '0;
endmodule
`default_nettype wire

### rtl/csr_triangle_join_counter.sv
// Triangle join counter over compressed adjacency lists: top level.
//
// Usage: items arrive on cmd_ch (valid/ready). Commands 0 to 3 write one
// word into the offset, adjacency, scan offset or scan vertex store;
// while idle, such loads stream at one word per cycle and give
// no result. Command 4 runs the join: the block walks the scan range, each
// neighbor list and each pair of intersected lists, then offers one result
// on res_ch holding the pair count, the match count and a saturation flag.
// The length of a run is set by the single read port of each store;
// cmd_ch.ready stays low for the whole run. The result sits in an output
// register, so further write commands are taken while the receiver stalls;
// a following run finishes its walk and then waits until the held result
// has been transferred. Configuration is written through cfg_we/cfg_idx/
// cfg_data while idle; this binds the user, the block does not enforce it.
// Reset clears the control state and the configuration to zero; the
// stores are undefined until written and are not cleared.
`default_nettype none
module csr_triangle_join_counter
	import ctj_pkg::*;
#(
	parameter int OFFSET_DEPTH = DEF_OFFSET_DEPTH,
	parameter int ADJ_DEPTH = DEF_ADJ_DEPTH,
	parameter int SCAN_OFFSET_DEPTH = DEF_SCAN_OFFSET_DEPTH,
	parameter int SCAN_DEPTH = DEF_SCAN_DEPTH,
	parameter int VERTEX_BITS = DEF_VERTEX_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ctj_cmd_if.sink                    cmd_ch,
	ctj_res_if.source                  res_ch
);
	localparam int OAW = $clog2(OFFSET_DEPTH);
	localparam int AAW = $clog2(ADJ_DEPTH);
	localparam int SOAW = $clog2(SCAN_OFFSET_DEPTH);
	localparam int SAW = $clog2(SCAN_DEPTH);
	localparam int VB = VERTEX_BITS;
	localparam int OIW = VB + 2;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SO0 = 5'd1;
	localparam logic [4:0] ST_SO1 = 5'd2;
	localparam logic [4:0] ST_SO2 = 5'd3;
	localparam logic [4:0] ST_SCAN = 5'd4;
	localparam logic [4:0] ST_SV = 5'd5;
	localparam logic [4:0] ST_J1 = 5'd6;
	localparam logic [4:0] ST_J2 = 5'd7;
	localparam logic [4:0] ST_A1 = 5'd8;
	localparam logic [4:0] ST_A2 = 5'd9;
	localparam logic [4:0] ST_PAIR = 5'd10;
	localparam logic [4:0] ST_Y = 5'd11;
	localparam logic [4:0] ST_B1 = 5'd12;
	localparam logic [4:0] ST_B2 = 5'd13;
	localparam logic [4:0] ST_MCHK = 5'd14;
	localparam logic [4:0] ST_M1 = 5'd15;
	localparam logic [4:0] ST_M2 = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;
	localparam logic [4:0] ST_J0 = 5'd18;

	logic [4:0]         state_q;
	logic [LABEL_W-1:0] scan_label_q;
	logic [BASE_W-1:0]  base_first_q, base_second_q, base_third_q;
	logic [SOFF_W-1:0]  i_q, last_q;
	logic [VB-1:0]      x_q, y_q, u_q;
	logic [OFF_W-1:0]   j_q, jl_q, xs_q, xe_q, pa_q, pb_q, ye_q;
	cnt_t               pair_q, match_q;
	logic               out_valid_q;
	cnt_t               out_pair_q, out_match_q;
	logic               out_sat_q;

	// Store ports.
	logic             off_re, adj_re, soff_re, sv_re;
	logic [OIW-1:0]   off_idx;
	logic [31:0]      adj_idx, soff_idx, sv_idx, waddr;
	logic [OFF_W-1:0] off_rd;
	logic [VB-1:0]    adj_rd, sv_rd;
	logic [SOFF_W-1:0] soff_rd;
	logic [BASE_W-1:0] off_base;
	logic [VB-1:0]    off_vert;
	logic             off_plus1;
	logic             wr_ok;
	logic             in_xfer;
	logic             out_load;
	logic             pair_live, merge_live;

	assign in_xfer = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign waddr = 32'(cmd_ch.addr);
	assign wr_ok = in_xfer;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_ch.ready);
	assign pair_live = (j_q < jl_q);
	assign merge_live = (pa_q < xe_q) && (pb_q < ye_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_label_q <= '0;
			base_first_q <= '0;
			base_second_q <= '0;
			base_third_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SCAN_LABEL:  scan_label_q <= cfg_data[LABEL_W-1:0];
				REG_BASE_FIRST:  base_first_q <= cfg_data[BASE_W-1:0];
				REG_BASE_SECOND: base_second_q <= cfg_data[BASE_W-1:0];
				REG_BASE_THIRD:  base_third_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read request steering.
	always_comb begin
		off_re = 1'b0;
		adj_re = 1'b0;
		soff_re = 1'b0;
		sv_re = 1'b0;
		off_base = base_first_q;
		off_vert = x_q;
		off_plus1 = 1'b0;
		adj_idx = 32'(j_q);
		soff_idx = 32'(scan_label_q);
		sv_idx = 32'(i_q);
		unique case (state_q)
			ST_SO0: soff_re = 1'b1;
			ST_SO1: begin
				soff_re = 1'b1;
				soff_idx = 32'(scan_label_q) + 32'd1;
			end
			ST_SCAN: sv_re = 1'b1;
			ST_J0: off_re = 1'b1;
			ST_J1: begin
				off_re = 1'b1;
				off_plus1 = 1'b1;
			end
			ST_J2: begin
				off_re = 1'b1;
				off_base = base_second_q;
			end
			ST_A1: begin
				off_re = 1'b1;
				off_base = base_second_q;
				off_plus1 = 1'b1;
			end
			ST_PAIR: adj_re = 1'b1;
			ST_Y: begin
				off_re = 1'b1;
				off_base = base_third_q;
				off_vert = adj_rd;
			end
			ST_B1: begin
				off_re = 1'b1;
				off_base = base_third_q;
				off_vert = y_q;
				off_plus1 = 1'b1;
			end
			ST_MCHK: begin
				adj_re = 1'b1;
				adj_idx = 32'(pa_q);
			end
			ST_M1: begin
				adj_re = 1'b1;
				adj_idx = 32'(pb_q);
			end
			default: ;
		endcase
		off_idx = OIW'(off_base) + OIW'(off_vert) + OIW'(off_plus1);
	end

	ctj_ram #(.WIDTH(OFF_W), .DEPTH(OFFSET_DEPTH)) u_off (
		.clk(clk),
		.we(wr_ok && cmd_ch.cmd == CMD_WR_OFF && waddr < 32'(OFFSET_DEPTH)),
		.waddr(waddr[OAW-1:0]),
		.wdata(cmd_ch.data[OFF_W-1:0]),
		.re(off_re),
		.rin(off_idx < OIW'(OFFSET_DEPTH)),
		.raddr(off_idx[OAW-1:0]),
		.rdata(off_rd)
	);

	ctj_ram #(.WIDTH(VB), .DEPTH(ADJ_DEPTH)) u_adj (
		.clk(clk),
		.we(wr_ok && cmd_ch.cmd == CMD_WR_ADJ && waddr < 32'(ADJ_DEPTH)),
		.waddr(waddr[AAW-1:0]),
		.wdata(cmd_ch.data[VB-1:0]),
		.re(adj_re),
		.rin(adj_idx < 32'(ADJ_DEPTH)),
		.raddr(adj_idx[AAW-1:0]),
		.rdata(adj_rd)
	);

	ctj_ram #(.WIDTH(SOFF_W), .DEPTH(SCAN_OFFSET_DEPTH)) u_soff (
		.clk(clk),
		.we(wr_ok && cmd_ch.cmd == CMD_WR_SOFF && waddr < 32'(SCAN_OFFSET_DEPTH)),
		.waddr(waddr[SOAW-1:0]),
		.wdata(cmd_ch.data[SOFF_W-1:0]),
		.re(soff_re),
		.rin(soff_idx < 32'(SCAN_OFFSET_DEPTH)),
		.raddr(soff_idx[SOAW-1:0]),
		.rdata(soff_rd)
	);

	ctj_ram #(.WIDTH(VB), .DEPTH(SCAN_DEPTH)) u_sv (
		.clk(clk),
		.we(wr_ok && cmd_ch.cmd == CMD_WR_SVERT && waddr < 32'(SCAN_DEPTH)),
		.waddr(waddr[SAW-1:0]),
		.wdata(cmd_ch.data[VB-1:0]),
		.re(sv_re),
		.rin(sv_idx < 32'(SCAN_DEPTH)),
		.raddr(sv_idx[SAW-1:0]),
		.rdata(sv_rd)
	);

	// Datapath registers; each read lands one state after it was issued.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SO1: i_q <= soff_rd;
			ST_SO2: last_q <= soff_rd;
			ST_SV: x_q <= sv_rd;
			ST_J1: j_q <= off_rd;
			ST_J2: jl_q <= off_rd;
			ST_A1: xs_q <= off_rd;
			ST_A2: xe_q <= off_rd;
			ST_PAIR: begin
				if (!pair_live) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_Y: y_q <= adj_rd;
			ST_B1: pb_q <= off_rd;
			ST_B2: begin
				ye_q <= off_rd;
				pa_q <= xs_q;
			end
			ST_MCHK: begin
				if (!merge_live) begin
					j_q <= j_q + 1'b1;
				end
			end
			ST_M1: u_q <= adj_rd;
			ST_M2: begin
				if (u_q < adj_rd) begin
					pa_q <= pa_q + 1'b1;
				end else if (u_q > adj_rd) begin
					pb_q <= pb_q + 1'b1;
				end else begin
					pa_q <= pa_q + 1'b1;
					pb_q <= pb_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pair_q <= '0;
			match_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && cmd_ch.cmd == CMD_RUN) begin
						pair_q <= '0;
						match_q <= '0;
						state_q <= ST_SO0;
					end
				end
				ST_SO0: state_q <= ST_SO1;
				ST_SO1: state_q <= ST_SO2;
				ST_SO2: state_q <= ST_SCAN;
				ST_SCAN: state_q <= (i_q < last_q) ? ST_SV : ST_DONE;
				ST_SV: state_q <= ST_J0;
				ST_J0: state_q <= ST_J1;
				ST_J1: state_q <= ST_J2;
				ST_J2: state_q <= ST_A1;
				ST_A1: state_q <= ST_A2;
				ST_A2: state_q <= ST_PAIR;
				ST_PAIR: state_q <= pair_live ? ST_Y : ST_SCAN;
				ST_Y: state_q <= ST_B1;
				ST_B1: state_q <= ST_B2;
				ST_B2: begin
					pair_q <= sat_inc(pair_q);
					state_q <= ST_MCHK;
				end
				ST_MCHK: state_q <= merge_live ? ST_M1 : ST_PAIR;
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					if (u_q == adj_rd) begin
						match_q <= sat_inc(match_q);
					end
					state_q <= ST_MCHK;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: the receiver may stall while new loads are taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pair_q <= pair_q;
			out_match_q <= match_q;
			out_sat_q <= (pair_q == CNT_MAX) || (match_q == CNT_MAX);
		end
	end

	assign res_ch.valid = out_valid_q;
	assign res_ch.pair_count = out_pair_q;
	assign res_ch.match_count = out_match_q;
	assign res_ch.saturated = out_sat_q;
endmodule
`default_nettype wire

### rtl/ctj_checker.sv
// Port-level checks of the triangle join counter and their binding.
`default_nettype none
module ctj_checker
	import ctj_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [CMD_W-1:0] in_cmd,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [CNT_W-1:0] out_pair,
	input wire logic [CNT_W-1:0] out_match,
	input wire logic             out_sat
);
	// A run holds off further commands for at least the start of its walk.
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_RUN |=> !in_ready)
		else $error("command taken right after a run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pair) && $stable(out_match))
		else $error("stalled result changed");

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_sat == (out_pair == CNT_MAX || out_match == CNT_MAX))
		else $error("saturation flag disagrees with counts");

	// Matches only come from pairs, so no pairs means no matches.
	a_no_pair_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_pair == '0 |-> out_match == '0)
		else $error("matches without pairs");
endmodule

bind csr_triangle_join_counter ctj_checker u_ctj_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(cmd_ch.valid),
	.in_ready(cmd_ch.ready),
	.in_cmd(cmd_ch.cmd),
	.out_valid(res_ch.valid),
	.out_ready(res_ch.ready),
	.out_pair(res_ch.pair_count),
	.out_match(res_ch.match_count),
	.out_sat(res_ch.saturated)
);
`default_nettype wire

### sim/csr_triangle_join_counter_tb.sv
// Self-checking testbench for the triangle join counter: store loads, joins and result counts.
`default_nettype none
module csr_triangle_join_counter_tb;
	import ctj_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;
	localparam int ITEM_TARGET = 1850;
	localparam int LONG_HOLD = 3000;

	typedef enum int {ST_OFF, ST_ADJ, ST_SOFF, ST_SVERT} store_e;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              known;
		cnt_t              pc;
		cnt_t              mc;
		logic              sat;
	} stim_row_t;

	typedef struct packed {
		cnt_t pc;
		cnt_t mc;
		logic sat;
	} counts_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ctj_cmd_if cmd_ch ();
	ctj_res_if res_ch ();

	csr_triangle_join_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cmd_ch(cmd_ch),
		.res_ch(res_ch)
	);

	always #5 clk = ~clk;

	// Shadow copy of the stores, with a mark for every entry written so far.
	logic [OFF_W-1:0]  off_mem [DEF_OFFSET_DEPTH];
	logic [31:0]       adj_mem [DEF_ADJ_DEPTH];
	logic [SOFF_W-1:0] soff_mem [DEF_SCAN_OFFSET_DEPTH];
	logic [31:0]       svert_mem [DEF_SCAN_DEPTH];
	bit off_wr [DEF_OFFSET_DEPTH];
	bit adj_wr [DEF_ADJ_DEPTH];
	bit soff_wr [DEF_SCAN_OFFSET_DEPTH];
	bit svert_wr [DEF_SCAN_DEPTH];
	logic [LABEL_W-1:0] scan_label = '0;
	logic [BASE_W-1:0]  base_first = '0;
	logic [BASE_W-1:0]  base_second = '0;
	logic [BASE_W-1:0]  base_third = '0;

	bit miss;
	store_e miss_kind;
	longint miss_idx;

	counts_t counts_q[$];
	int errors = 0;
	int items_sent = 0;
	int burst_left = 1;
	bit hold_req = 0;

	function automatic void note_miss(store_e k, longint i, bit wr);
		if (!wr && !miss) begin
			miss = 1;
			miss_kind = k;
			miss_idx = i;
		end
	endfunction

	function automatic longint rd_off(longint i);
		if (i >= DEF_OFFSET_DEPTH) return 0;
		note_miss(ST_OFF, i, off_wr[i]);
		return off_mem[i];
	endfunction

	function automatic longint rd_adj(longint i);
		if (i >= DEF_ADJ_DEPTH) return 0;
		note_miss(ST_ADJ, i, adj_wr[i]);
		return adj_mem[i];
	endfunction

	function automatic longint rd_soff(longint i);
		if (i >= DEF_SCAN_OFFSET_DEPTH) return 0;
		note_miss(ST_SOFF, i, soff_wr[i]);
		return soff_mem[i];
	endfunction

	function automatic longint rd_svert(longint i);
		if (i >= DEF_SCAN_DEPTH) return 0;
		note_miss(ST_SVERT, i, svert_wr[i]);
		return svert_mem[i];
	endfunction

	function automatic cnt_t sat_add(cnt_t a, longint b);
		longint s;
		s = longint'(a) + b;
		return (s > longint'(CNT_MAX)) ? CNT_MAX : cnt_t'(s);
	endfunction

	function automatic longint merge_matches(longint a, longint b);
		longint xa, xe, ya, ye, u, v, n;
		xa = rd_off(a);
		xe = rd_off(a + 1);
		ya = rd_off(b);
		ye = rd_off(b + 1);
		n = 0;
		while (xa < xe && ya < ye && !miss) begin
			u = rd_adj(xa);
			v = rd_adj(ya);
			if (u < v) begin
				xa++;
			end else if (u > v) begin
				ya++;
			end else begin
				n++;
				xa++;
				ya++;
			end
		end
		return n;
	endfunction

	// Walks the scan range as the block does; sets miss on the first unwritten read.
	function automatic counts_t join_counts();
		counts_t r;
		longint sf, sl, i, j, x, y, jf, jl;
		r = '0;
		sf = rd_soff(scan_label);
		sl = rd_soff(longint'(scan_label) + 1);
		for (i = sf; i < sl && !miss; i++) begin
			x = rd_svert(i);
			jf = rd_off(base_first + x);
			jl = rd_off(base_first + x + 1);
			for (j = jf; j < jl && !miss; j++) begin
				y = rd_adj(j);
				r.pc = sat_add(r.pc, 1);
				r.mc = sat_add(r.mc, merge_matches(base_second + x, base_third + y));
			end
		end
		r.sat = (r.pc == CNT_MAX) || (r.mc == CNT_MAX);
		return r;
	endfunction

	function automatic void apply_item(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic known, counts_t typed);
		case (c)
			CMD_WR_OFF: if (a < DEF_OFFSET_DEPTH) begin
				off_mem[a] = d[OFF_W-1:0];
				off_wr[a] = 1;
			end
			CMD_WR_ADJ: if (a < DEF_ADJ_DEPTH) begin
				adj_mem[a] = d;
				adj_wr[a] = 1;
			end
			CMD_WR_SOFF: if (a < DEF_SCAN_OFFSET_DEPTH) begin
				soff_mem[a] = d[SOFF_W-1:0];
				soff_wr[a] = 1;
			end
			CMD_WR_SVERT: if (a < DEF_SCAN_DEPTH) begin
				svert_mem[a] = d;
				svert_wr[a] = 1;
			end
			CMD_RUN: begin
				miss = 0;
				counts_q.push_back(known ? typed : join_counts());
			end
			default: ;
		endcase
	endfunction

	// Words are kept small so that lists stay short and joins stay cheap.
	function automatic logic [DATA_W-1:0] gen_word(store_e k, longint idx);
		case (k)
			ST_OFF: return ($urandom & 32'hFFFF8000) | $urandom_range(0, 12);
			ST_ADJ: return ($urandom_range(0, 3) != 0) ? 32'(idx >> 1) : $urandom_range(0, 15);
			ST_SOFF: return ($urandom & 32'hFFFFE000) | $urandom_range(0, 8);
			default: return ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 15);
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] store_cmd(store_e k);
		case (k)
			ST_OFF: return CMD_WR_OFF;
			ST_ADJ: return CMD_WR_ADJ;
			ST_SOFF: return CMD_WR_SOFF;
			default: return CMD_WR_SVERT;
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, input logic known = 1'b0, input counts_t typed = '0);
		@(negedge clk);
		cmd_ch.valid = 1'b1;
		cmd_ch.cmd = c;
		cmd_ch.addr = a;
		cmd_ch.data = d;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		apply_item(c, a, d, known, typed);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			cmd_ch.valid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic write_store(store_e k, longint idx);
		send_item(store_cmd(k), ADDR_W'(idx), gen_word(k, idx));
	endtask

	// Writes every entry the join would read unwritten, then starts the join.
	// A join that would still read unwritten entries is not started.
	task automatic start_join();
		counts_t scratch;
		for (int n = 0; n < 500; n++) begin
			miss = 0;
			scratch = join_counts();
			if (!miss) break;
			write_store(miss_kind, miss_idx);
		end
		miss = 0;
		scratch = join_counts();
		if (!miss) send_item(CMD_RUN, ADDR_W'($urandom), $urandom);
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (counts_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		burst_left = $urandom_range(1, 40);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		case (idx)
			REG_SCAN_LABEL: scan_label = val[LABEL_W-1:0];
			REG_BASE_FIRST: base_first = val;
			REG_BASE_SECOND: base_second = val;
			default: base_third = val;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic report_mismatch(string what, longint want, longint got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// Receiver: ready follows a changing pattern, with one long hold on request.
	initial begin
		int mode_left;
		int mode;
		res_ch.ready = 1'b0;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 0;
			end
			if (mode_left <= 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 200);
			end
			mode_left--;
			case (mode)
				0: res_ch.ready = 1'b1;
				1: res_ch.ready = $urandom_range(0, 1);
				default: res_ch.ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		counts_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (counts_q.size() == 0) begin
				report_mismatch("unexpected result transfer", 0, 1);
			end else begin
				want = counts_q.pop_front();
				if (res_ch.pair_count !== want.pc)
					report_mismatch("pair_count", want.pc, res_ch.pair_count);
				if (res_ch.match_count !== want.mc)
					report_mismatch("match_count", want.mc, res_ch.match_count);
				if (res_ch.saturated !== want.sat)
					report_mismatch("saturated", want.sat, res_ch.saturated);
			end
		end
	end

	initial begin
		#200_000_000;
		$display("Test completed with failures");
		$finish;
	end

	stim_row_t directed [24] = '{
		'{CMD_WR_SOFF, 14'd0, 32'd5, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SOFF, 14'd1, 32'd5, 1'b0, 32'd0, 32'd0, 1'b0},
		// Empty scan range: both counts stay zero.
		'{CMD_RUN, 14'd16383, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SOFF, 14'd1, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0},
		// Reversed scan range is empty as well.
		'{CMD_RUN, 14'd0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0},
		'{CMD_UNUSED_A, 14'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_UNUSED_B, 14'd16383, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_UNUSED_C, 14'd1234, 32'h55AA55AA, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_OFF, 14'd16383, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SOFF, 14'd64, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SVERT, 14'd16383, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_ADJ, 14'd16383, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_OFF, 14'd4095, 32'h00007FFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SOFF, 14'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SOFF, 14'd1, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_SVERT, 14'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		// A huge vertex id puts its offset entries out of range.
		'{CMD_WR_SVERT, 14'd1, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_OFF, 14'd0, 32'hFFFF8000, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_OFF, 14'd1, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_OFF, 14'd2, 32'd3, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_ADJ, 14'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_ADJ, 14'd1, 32'd1, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_WR_ADJ, 14'd2, 32'd1, 1'b0, 32'd0, 32'd0, 1'b0},
		'{CMD_RUN, 14'd77, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0}
	};

	initial begin
		int phase;
		int act;
		int k;
		logic [CMD_W-1:0] c;
		counts_t typed;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = '0;
		cmd_ch.addr = '0;
		cmd_ch.data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			typed = '{directed[i].pc, directed[i].mc, directed[i].sat};
			send_item(directed[i].cmd, directed[i].addr, directed[i].data,
				directed[i].known, typed);
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			if (phase == 0) begin
				write_cfg(REG_SCAN_LABEL, 12'hFFE);
				write_cfg(REG_BASE_FIRST, 12'hFFF);
				write_cfg(REG_BASE_SECOND, 12'hFFF);
				write_cfg(REG_BASE_THIRD, 12'hFFF);
			end else if (phase == 1) begin
				write_cfg(REG_SCAN_LABEL, '0);
				write_cfg(REG_BASE_FIRST, '0);
				write_cfg(REG_BASE_SECOND, '0);
				write_cfg(REG_BASE_THIRD, '0);
			end else begin
				write_cfg(REG_SCAN_LABEL,
					CFG_DATA_W'(($urandom & 32'hFC0) | $urandom_range(0, 62)));
				for (int r = 1; r < 4; r++)
					write_cfg(CFG_IDX_W'(r), ($urandom_range(0, 4) == 0) ?
						CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 40)));
			end
			// Hold the receiver off while joins keep arriving.
			if (phase == 2) hold_req = 1;
			repeat (25) begin
				act = $urandom_range(0, 9);
				if (act < 3) begin
					c = CMD_W'($urandom);
					case (c)
						CMD_RUN: start_join();
						CMD_WR_OFF: send_item(c, ADDR_W'($urandom), gen_word(ST_OFF, 0));
						CMD_WR_SOFF: send_item(c, ADDR_W'($urandom), gen_word(ST_SOFF, 0));
						default: send_item(c, ADDR_W'($urandom), $urandom);
					endcase
				end else if (act < 6) begin
					k = $urandom_range(0, 3);
					case (store_e'(k))
						ST_OFF: write_store(ST_OFF, $urandom_range(0, 60));
						ST_ADJ: write_store(ST_ADJ, $urandom_range(0, 60));
						ST_SOFF: write_store(ST_SOFF, scan_label + $urandom_range(0, 1));
						default: write_store(ST_SVERT, $urandom_range(0, 15));
					endcase
				end else begin
					start_join();
				end
			end
			phase++;
		end

		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (counts_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire
